FILE: design/hs1_pkg.sv
// ----------------------------------------------------------------------------
// hs1_pkg: shared types and tables for the HID report to set 1 translator
// Holds the port word types, the usage to scan code table and the modifier
// scan codes.
// ----------------------------------------------------------------------------
package hs1_pkg;

    // One boot keyboard report.
    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_report;

    // One scan code byte on the output side.
    typedef struct packed {
        logic [7:0] scancode_byte;
        logic       last_byte;
    } t_scan;

    localparam int         MAX_SLOTS  = 6;
    localparam int         MOD_BITS   = 8;
    localparam logic [7:0] PREFIX_E0  = 8'hE0;
    localparam logic [7:0] ROLLOVER   = 8'h01;
    localparam logic [7:0] USAGE_END  = 8'h68;

    // Bit 7 of a table entry marks an extended code that needs the prefix.
    localparam logic [7:0] MOD_MAP [0:MOD_BITS-1] = '{
        8'h1D, 8'h2A, 8'h38, 8'hDB, 8'h9D, 8'h36, 8'hB8, 8'hDC
    };

    localparam logic [7:0] USAGE_MAP [0:103] = '{
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
        8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
        8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
        8'h15, 8'h2C,
        8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
        8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39,
        8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28,
        8'h29, 8'h33, 8'h34, 8'h35, 8'h3A,
        8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42,
        8'h43, 8'h44, 8'h57, 8'h58,
        8'h00, 8'h46, 8'h00,
        8'hD2, 8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1,
        8'hCD, 8'hCB, 8'hD0, 8'hC8,
        8'h45, 8'hB5, 8'h37, 8'h4A, 8'h4E, 8'h9C,
        8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47, 8'h48,
        8'h49, 8'h52, 8'h53,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    // Scan code for a HID usage; zero means the usage produces nothing.
    function automatic logic [7:0] usage_lookup(input logic [7:0] usage);
        logic [7:0] code;
        code = 8'h00;
        if (usage < USAGE_END) begin
            code = USAGE_MAP[usage[6:0]];
        end
        return code;
    endfunction

endpackage

FILE: design/hs1_fifo.sv
// ----------------------------------------------------------------------------
// hs1_fifo: small register queue between front and back
// Holds classified reports so that the front can accept while the back is
// still sending bytes of an earlier report.
// ----------------------------------------------------------------------------
module hs1_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_fill, n_fill;
    logic             do_push, do_pop;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: design/hs1_front.sv
// ----------------------------------------------------------------------------
// hs1_front: report intake and change classification
// Compares each accepted report with the stored one and builds the ordered
// list of candidate codes (modifier changes, breaks, makes) for the back.
// ----------------------------------------------------------------------------
module hs1_front import hs1_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_report i_report,
    input  logic    i_full,
    output logic    o_push,
    output logic [(MOD_BITS + 2 * KEY_SLOTS) * 9 + MOD_BITS - 1:0] o_entry
);

    localparam int NCAND      = MOD_BITS + 2 * KEY_SLOTS;
    localparam int FIRST_MAKE = MOD_BITS + KEY_SLOTS;

    logic [7:0] r_prev_mods;
    logic [7:0] r_prev_keys [0:KEY_SLOTS-1];
    logic [7:0] keys_all [0:MAX_SLOTS-1];
    logic [KEY_SLOTS-1:0] held_now;
    logic [KEY_SLOTS-1:0] held_before;
    logic [NCAND-1:0][7:0] codes;
    logic [NCAND-1:0]      mask;
    logic                  accept;

    assign keys_all[0] = i_report.key_slot_0;
    assign keys_all[1] = i_report.key_slot_1;
    assign keys_all[2] = i_report.key_slot_2;
    assign keys_all[3] = i_report.key_slot_3;
    assign keys_all[4] = i_report.key_slot_4;
    assign keys_all[5] = i_report.key_slot_5;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        held_now    = '0;
        held_before = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (keys_all[j] == r_prev_keys[i]) begin
                    held_now[i] = 1'b1;
                end
                if (r_prev_keys[j] == keys_all[i]) begin
                    held_before[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MOD_BITS; i++) begin
            mask[i]  = (i_report.modifiers[i] != r_prev_mods[i]);
            codes[i] = MOD_MAP[i];
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            codes[MOD_BITS + i] = usage_lookup(r_prev_keys[i]);
            mask[MOD_BITS + i]  = (r_prev_keys[i] != 8'h00) && !held_now[i]
                                  && (codes[MOD_BITS + i] != 8'h00);
            codes[FIRST_MAKE + i] = usage_lookup(keys_all[i]);
            mask[FIRST_MAKE + i]  = (keys_all[i] != 8'h00) && (keys_all[i] != ROLLOVER)
                                    && !held_before[i]
                                    && (codes[FIRST_MAKE + i] != 8'h00);
        end
    end

    // Reports that change nothing are not queued at all.
    assign o_push  = accept && (mask != '0);
    assign o_entry = {i_report.modifiers, mask, codes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev_keys[i] <= '0;
            end
        end else if (accept) begin
            r_prev_mods <= i_report.modifiers;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev_keys[i] <= keys_all[i];
            end
        end
    end

endmodule

FILE: design/hs1_back.sv
// ----------------------------------------------------------------------------
// hs1_back: scan code byte sequencer
// Walks one queued report's candidate list, one output byte per cycle unless
// stalled, inserting prefixes, applying the byte limit and marking the final byte.
// ----------------------------------------------------------------------------
module hs1_back import hs1_pkg::*; #(
    parameter int KEY_SLOTS = 6,
    parameter int OUT_LIMIT = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  logic [(MOD_BITS + 2 * KEY_SLOTS) * 9 + MOD_BITS - 1:0] i_q_entry,
    output logic  o_q_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_scan o_scan
);

    localparam int NCAND      = MOD_BITS + 2 * KEY_SLOTS;
    localparam int FIRST_MAKE = MOD_BITS + KEY_SLOTS;
    localparam int PW         = $clog2(NCAND);
    localparam int CW         = $clog2(OUT_LIMIT + 1);

    logic [NCAND-1:0][7:0] r_codes;
    logic [NCAND-1:0]      r_mask;
    logic [7:0]            r_modp;
    logic [CW-1:0]         r_count;
    logic                  r_pre;
    logic                  r_busy;
    logic                  r_ovalid;
    t_scan                 r_scan;

    logic [NCAND-1:0][7:0] q_codes;
    logic [NCAND-1:0]      q_mask;
    logic [7:0]            q_modp;

    logic [PW-1:0]    pick;
    logic [7:0]       code;
    logic             pressed;
    logic             is_pre;
    logic [NCAND-1:0] rest;
    logic             last;
    logic             can_load;
    logic             fire;
    logic             done;

    assign {q_modp, q_mask, q_codes} = i_q_entry;

    // Lowest pending candidate comes first.
    always_comb begin
        pick = '0;
        for (int i = NCAND - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = PW'(i);
            end
        end
    end

    always_comb begin
        code   = r_codes[pick];
        is_pre = code[7] && !r_pre;
        rest   = r_mask & ~(NCAND'(1) << pick);
        if (pick < PW'(MOD_BITS)) begin
            pressed = r_modp[pick[2:0]];
        end else begin
            pressed = (pick >= PW'(FIRST_MAKE));
        end
        // The next code is dropped once the byte count plus three reaches the limit.
        last = !is_pre && ((rest == '0) ||
               ({2'b00, r_count} + (CW + 2)'(3) >= (CW + 2)'(OUT_LIMIT)));
    end

    assign can_load = !r_ovalid || !i_stall;
    assign fire     = r_busy && can_load;
    assign done     = fire && last;
    assign o_q_pop  = i_q_valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pre    <= 1'b0;
            r_count  <= '0;
            r_mask   <= '0;
        end else begin
            if (can_load) begin
                r_ovalid <= fire;
            end
            if (o_q_pop) begin
                r_busy  <= 1'b1;
                r_pre   <= 1'b0;
                r_count <= '0;
                r_mask  <= q_mask;
            end else if (fire) begin
                r_count <= r_count + 1'b1;
                if (is_pre) begin
                    r_pre <= 1'b1;
                end else begin
                    r_pre  <= 1'b0;
                    r_mask <= rest;
                end
                if (done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_codes <= q_codes;
            r_modp  <= q_modp;
        end
        if (fire) begin
            r_scan.scancode_byte <= is_pre ? PREFIX_E0 : {!pressed, code[6:0]};
            r_scan.last_byte     <= last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_scan  = r_scan;

endmodule

FILE: design/hid_report_to_set1_scancodes.sv
// ----------------------------------------------------------------------------
// hid_report_to_set1_scancodes: boot keyboard report to scan code set 1
// Turns each HID boot keyboard report into the set 1 make and break bytes
// that describe how it differs from the report before it.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Word
//  --------+---------------------+------------------------------------------
//  input   | i_valid / o_stall   | i_report: modifiers and six key slots
//  output  | o_valid / i_stall   | o_scan: scan code byte and last-byte flag
//
// The front takes a report in any cycle in which the two-entry queue has
// room, compares it with the stored report in that same cycle and replaces
// the stored report. The back sends one byte per cycle while the output is
// not stalled (up to 31 bytes per report at the default limit); the output byte
// sequencer sets the sustained rate. A report that changes nothing yields no
// bytes and occupies no queue entry. Reset clears the stored report to all
// zero, empties the queue and drops any byte in flight. A stall on the output
// holds the registered byte and the back; the front keeps accepting until the
// queue fills.
//
module hid_report_to_set1_scancodes import hs1_pkg::*; #(
    parameter int KEY_SLOTS = 6,
    parameter int OUT_LIMIT = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_report i_report,
    output logic    o_valid,
    input  logic    i_stall,
    output t_scan   o_scan
);

    // Each queue entry holds the candidate codes, their pending mask and the
    // new modifier bits, which decide make or break for modifier changes.
    localparam int NCAND = MOD_BITS + 2 * KEY_SLOTS;
    localparam int EW    = NCAND * 9 + MOD_BITS;

    logic          push;
    logic [EW-1:0] push_entry;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [EW-1:0] q_entry;

    // The front classifies the report against the stored one.
    hs1_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_report (i_report),
        .i_full   (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Decouples intake from byte output.
    hs1_fifo #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    // The back serializes the codes into bytes.
    hs1_back #(
        .KEY_SLOTS (KEY_SLOTS),
        .OUT_LIMIT (OUT_LIMIT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_scan    (o_scan)
    );

endmodule
